### rtl/core/sqch_pkg.sv
// Package for the square-wave sound channel: event codes, register
// addresses, duty table and the state and result structs.
// No dependencies.
`default_nettype none

package sqch_pkg;

  typedef enum logic [2:0] {
    ACT_CLOCK    = 3'd0,
    ACT_LENGTH   = 3'd1,
    ACT_SWEEP    = 3'd2,
    ACT_ENVELOPE = 3'd3,
    ACT_WRITE    = 3'd4,
    ACT_READ     = 3'd5
  } action_e;

  localparam logic [2:0] ADDR_SWEEP    = 3'd0;
  localparam logic [2:0] ADDR_DUTY_LEN = 3'd1;
  localparam logic [2:0] ADDR_ENVELOPE = 3'd2;
  localparam logic [2:0] ADDR_FREQ_LO  = 3'd3;
  localparam logic [2:0] ADDR_FREQ_HI  = 3'd4;

  localparam int unsigned FreqW  = 11;
  localparam int unsigned TimerW = 14;
  localparam logic [7:0] ReadOpen = 8'hFF;

  // Duty waveforms, position 0 in bit 7.
  localparam logic [3:0][7:0] DutyPattern = {8'h7E, 8'h87, 8'h81, 8'h01};

  typedef struct packed {
    logic [FreqW-1:0]  tone_freq;
    logic [FreqW-1:0]  shadow_freq;
    logic [TimerW-1:0] period_timer;
    logic [2:0]        duty_pos;
    logic [1:0]        duty_sel;
    logic [6:0]        length_left;
    logic              length_on;
    logic              enabled;
    logic [3:0]        cur_volume;
    logic [3:0]        init_volume;
    logic              vol_rising;
    logic [2:0]        env_period;
    logic [2:0]        env_count;
    logic              env_stopped;
    logic [2:0]        sweep_shift;
    logic              sweep_down;
    logic [2:0]        sweep_period;
    logic [2:0]        sweep_count;
    logic              sweep_active;
    logic [3:0]        sample_hold;
  } chan_state_t;

  typedef struct packed {
    logic       channel_on;
    logic [7:0] read_data;
    logic [3:0] sample;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/sqch_step.sv
// Next-state and result logic for one channel event.
// Depends on sqch_pkg.
`default_nettype none

module sqch_step (
  input  sqch_pkg::chan_state_t st_i,
  input  logic [2:0]            action_i,
  input  logic [2:0]            reg_addr_i,
  input  logic [7:0]            write_data_i,
  output sqch_pkg::chan_state_t st_o,
  output sqch_pkg::result_t     res_o
);
  import sqch_pkg::*;

  // shadow +/- (shadow >> shift); bit 11 flags overflow past 2047
  function automatic logic [FreqW:0] next_sweep(input logic [FreqW-1:0] f,
                                                input logic [2:0] shift,
                                                input logic down);
    logic [FreqW:0] delta;
    delta = {1'b0, f >> shift};
    if (down) next_sweep = {1'b0, f} - delta;
    else      next_sweep = {1'b0, f} + delta;
  endfunction

  function automatic logic [TimerW-1:0] reload(input logic [FreqW-1:0] f);
    logic [FreqW:0] span;
    span = (FreqW+1)'(2048) - {1'b0, f};
    reload = {span, 2'b00};
  endfunction

  logic [FreqW:0]   sw_first, sw_second, sw_trig;
  logic [FreqW-1:0] trig_freq;
  logic             duty_bit;
  chan_state_t      st;
  logic [7:0]       rd;

  assign trig_freq = {write_data_i[2:0], st_i.tone_freq[7:0]};
  assign sw_first  = next_sweep(st_i.shadow_freq, st_i.sweep_shift, st_i.sweep_down);
  assign sw_second = next_sweep(sw_first[FreqW-1:0], st_i.sweep_shift, st_i.sweep_down);
  assign sw_trig   = next_sweep(trig_freq, st_i.sweep_shift, st_i.sweep_down);
  assign duty_bit  = DutyPattern[st_i.duty_sel][3'd7 - st_i.duty_pos];

  always_comb begin
    st = st_i;
    rd = 8'h00;
    case (action_e'(action_i))
      ACT_CLOCK: begin
        st.sample_hold = (st_i.enabled && duty_bit) ? st_i.cur_volume : 4'h0;
        if (st_i.period_timer <= TimerW'(1)) begin
          st.period_timer = reload(st_i.tone_freq);
          st.duty_pos     = st_i.duty_pos + 3'd1;
        end else begin
          st.period_timer = st_i.period_timer - TimerW'(1);
        end
      end
      ACT_LENGTH: begin
        if (st_i.length_on && st_i.length_left != 7'd0) begin
          st.length_left = st_i.length_left - 7'd1;
          if (st_i.length_left == 7'd1) st.enabled = 1'b0;
        end
      end
      ACT_SWEEP: begin
        if (st_i.sweep_active && st_i.sweep_count != 3'd0 && st_i.sweep_period != 3'd0) begin
          st.sweep_count = st_i.sweep_count - 3'd1;
          if (st_i.sweep_count == 3'd1) begin
            st.sweep_count = st_i.sweep_period;
            if (sw_first[FreqW]) begin
              st.enabled = 1'b0;
            end else if (st_i.sweep_shift != 3'd0) begin
              st.tone_freq   = sw_first[FreqW-1:0];
              st.shadow_freq = sw_first[FreqW-1:0];
              if (sw_second[FreqW]) st.enabled = 1'b0;
            end
          end
        end
      end
      ACT_ENVELOPE: begin
        if (!st_i.env_stopped && st_i.env_count != 3'd0) begin
          st.env_count = st_i.env_count - 3'd1;
          if (st_i.env_count == 3'd1) begin
            if (st_i.vol_rising && st_i.cur_volume != 4'hF)
              st.cur_volume = st_i.cur_volume + 4'h1;
            else if (!st_i.vol_rising && st_i.cur_volume != 4'h0)
              st.cur_volume = st_i.cur_volume - 4'h1;
            else
              st.env_stopped = 1'b1;
            st.env_count = st_i.env_period;
          end
        end
      end
      ACT_WRITE: begin
        case (reg_addr_i)
          ADDR_SWEEP: begin
            st.sweep_shift  = write_data_i[2:0];
            st.sweep_down   = write_data_i[3];
            st.sweep_period = write_data_i[6:4];
          end
          ADDR_DUTY_LEN: begin
            st.length_left = 7'd64 - {1'b0, write_data_i[5:0]};
            st.duty_sel    = write_data_i[7:6];
          end
          ADDR_ENVELOPE: begin
            st.env_period  = write_data_i[2:0];
            st.vol_rising  = write_data_i[3];
            st.init_volume = write_data_i[7:4];
            if (write_data_i[7:3] == 5'd0) st.enabled = 1'b0;
          end
          ADDR_FREQ_LO: begin
            st.tone_freq = {st_i.tone_freq[10:8], write_data_i};
          end
          ADDR_FREQ_HI: begin
            st.tone_freq = trig_freq;
            st.length_on = write_data_i[6];
            if (write_data_i[7]) begin
              st.enabled = st_i.vol_rising || st_i.init_volume != 4'h0;
              if (st_i.length_left == 7'd0) st.length_left = 7'd64;
              st.period_timer = reload(trig_freq);
              st.env_count    = st_i.env_period;
              st.env_stopped  = 1'b0;
              st.cur_volume   = st_i.init_volume;
              st.shadow_freq  = trig_freq;
              st.sweep_count  = st_i.sweep_period;
              st.sweep_active = st_i.sweep_period != 3'd0 || st_i.sweep_shift != 3'd0;
              if (st_i.sweep_shift != 3'd0 && sw_trig[FreqW]) begin
                st.sweep_active = 1'b0;
                st.enabled      = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      ACT_READ: begin
        case (reg_addr_i)
          ADDR_SWEEP:    rd = {1'b0, st_i.sweep_period, st_i.sweep_down, st_i.sweep_shift};
          ADDR_DUTY_LEN: rd = {st_i.duty_sel, 6'd0};
          ADDR_ENVELOPE: rd = {st_i.init_volume, st_i.vol_rising, st_i.env_period};
          default:       rd = ReadOpen;
        endcase
      end
      default: ;
    endcase
  end

  assign st_o             = st;
  assign res_o.sample     = st.sample_hold;
  assign res_o.read_data  = rd;
  assign res_o.channel_on = st.enabled;

endmodule

`default_nettype wire

### rtl/core/square_wave_sound_channel_core.sv
// Top level of the square-wave sound channel: channel state registers,
// event decode through sqch_step, and a two-entry output buffer.
// Depends on sqch_pkg and sqch_step.
`default_nettype none

// Square-wave channel with frequency timer, duty sequencer, length counter,
// volume envelope and frequency sweep, driven by one event item at a time.
// The event kind (clock cycle, length tick, sweep tick, envelope tick,
// register write, register read) arrives on s_axis_tuser_i; the register
// address and write byte arrive on s_axis_tdata_i. Every accepted item
// yields exactly one result item: the held sample, the readback byte (zero
// unless the item was a read) and the channel-enable flag. The block takes
// one item per clock while s_axis_tready_o is high: the whole event is
// applied to the state registers in the cycle it is accepted, and its
// result is registered into the output buffer. A two-entry output buffer
// (output register plus skid) keeps input acceptance going while a result
// waits; s_axis_tready_o drops only once both entries are full, and a
// stalled sink therefore holds back at most two items.

module square_wave_sound_channel_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input: tdata = reg_addr[2:0], write_data[10:3], zero [15:11]
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,
  // input: tuser = action[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  // output: tdata = sample[3:0], read_data[11:4], channel_on[12], zero [15:13]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o
);
  import sqch_pkg::*;

  chan_state_t state_q, state_d;
  result_t     res_new;
  result_t     out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        in_fire, out_fire;

  assign s_axis_tready_o = !skid_valid_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire        = out_valid_q && m_axis_tready_i;

  sqch_step u_step (
    .st_i         (state_q),
    .action_i     (s_axis_tuser_i),
    .reg_addr_i   (s_axis_tdata_i[2:0]),
    .write_data_i (s_axis_tdata_i[10:3]),
    .st_o         (state_d),
    .res_o        (res_new)
  );

  // Channel state: advance on every accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Output buffer control: refill the output register from the skid entry
  // first, else from the new item; park the new item in skid when blocked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_fire || !out_valid_q) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Output buffer payload: no reset, qualified by the valid flags above.
  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (in_fire) out_q <= res_new;
    end else if (in_fire) begin
      skid_q <= res_new;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.channel_on, out_q.read_data, out_q.sample};

endmodule

`default_nettype wire

### tb/tb_square_wave_sound_channel_core.sv
// Self-checking testbench for square_wave_sound_channel_core: directed and random event
// streams, predicted with a behavioral channel model held in a small scoreboard class.
// Depends on sqch_pkg and the channel RTL only.

module tb_square_wave_sound_channel_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sqch_pkg::*;

  // Event codes past the last defined action, and a spare address; the channel must leave its state alone.
  localparam logic [2:0] ActSpareLo = 3'd6;
  localparam logic [2:0] ActSpareHi = 3'd7;
  localparam logic [2:0] AddrSpare  = 3'd6;

  localparam int RandomItems = 1300;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 8;

  // Tracks the channel state, predicts the result of each event and checks results.
  class channel_tracker;
    chan_state_t st;
    result_t     awaited_q[$];
    int          mismatches;

    function new();
      st = '0;
      mismatches = 0;
    endfunction

    // Frequency the next sweep step would produce, before any overflow check.
    function int sweep_target();
      int delta;
      delta = int'(st.shadow_freq) >> st.sweep_shift;
      return st.sweep_down ? int'(st.shadow_freq) - delta : int'(st.shadow_freq) + delta;
    endfunction

    function logic [TimerW-1:0] period_reload();
      return TimerW'((2048 - int'(st.tone_freq)) * 4);
    endfunction

    function void note_event(logic [2:0] act, logic [2:0] addr, logic [7:0] din);
      result_t    r;
      logic [7:0] wave;
      int         f;
      r = '0;
      case (act)
        ACT_CLOCK: begin
          case (st.duty_sel)
            2'd0:    wave = 8'h01;
            2'd1:    wave = 8'h81;
            2'd2:    wave = 8'h87;
            default: wave = 8'h7E;
          endcase
          // Sample from the state before the timer moves.
          st.sample_hold = (st.enabled && wave[3'd7 - st.duty_pos]) ? st.cur_volume : 4'd0;
          if (st.period_timer <= 1) begin
            st.period_timer = period_reload();
            st.duty_pos = st.duty_pos + 3'd1;
          end else begin
            st.period_timer = st.period_timer - 1'b1;
          end
        end
        ACT_LENGTH: begin
          if (st.length_on && st.length_left != 0) begin
            st.length_left = st.length_left - 1'b1;
            if (st.length_left == 0) st.enabled = 1'b0;
          end
        end
        ACT_SWEEP: begin
          if (st.sweep_active && st.sweep_count != 0 && st.sweep_period != 0) begin
            st.sweep_count = st.sweep_count - 1'b1;
            if (st.sweep_count == 0) begin
              st.sweep_count = st.sweep_period;
              f = sweep_target();
              if (f > 2047) begin
                st.enabled = 1'b0;
              end else if (st.sweep_shift != 0) begin
                st.tone_freq = f[FreqW-1:0];
                st.shadow_freq = f[FreqW-1:0];
                if (sweep_target() > 2047) st.enabled = 1'b0;
              end
            end
          end
        end
        ACT_ENVELOPE: begin
          if (!st.env_stopped && st.env_count != 0) begin
            st.env_count = st.env_count - 1'b1;
            if (st.env_count == 0) begin
              if (st.vol_rising && st.cur_volume != 4'hF) st.cur_volume = st.cur_volume + 1'b1;
              else if (!st.vol_rising && st.cur_volume != 0) st.cur_volume = st.cur_volume - 1'b1;
              else st.env_stopped = 1'b1;
              st.env_count = st.env_period;
            end
          end
        end
        ACT_WRITE: begin
          case (addr)
            ADDR_SWEEP: begin
              st.sweep_shift  = din[2:0];
              st.sweep_down   = din[3];
              st.sweep_period = din[6:4];
            end
            ADDR_DUTY_LEN: begin
              st.length_left = 7'(64 - int'(din[5:0]));
              st.duty_sel    = din[7:6];
            end
            ADDR_ENVELOPE: begin
              st.env_period  = din[2:0];
              st.vol_rising  = din[3];
              st.init_volume = din[7:4];
              if (din[7:3] == 5'd0) st.enabled = 1'b0;
            end
            ADDR_FREQ_LO: st.tone_freq[7:0] = din;
            ADDR_FREQ_HI: begin
              st.tone_freq[10:8] = din[2:0];
              st.length_on = din[6];
              if (din[7]) begin
                st.enabled = st.vol_rising || st.init_volume != 0;
                if (st.length_left == 0) st.length_left = 7'd64;
                st.period_timer = period_reload();
                st.env_count    = st.env_period;
                st.env_stopped  = 1'b0;
                st.cur_volume   = st.init_volume;
                st.shadow_freq  = st.tone_freq;
                st.sweep_count  = st.sweep_period;
                st.sweep_active = st.sweep_period != 0 || st.sweep_shift != 0;
                if (st.sweep_shift != 0 && sweep_target() > 2047) begin
                  st.sweep_active = 1'b0;
                  st.enabled = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
        ACT_READ: begin
          case (addr)
            ADDR_SWEEP:    r.read_data = {1'b0, st.sweep_period, st.sweep_down, st.sweep_shift};
            ADDR_DUTY_LEN: r.read_data = {st.duty_sel, 6'd0};
            ADDR_ENVELOPE: r.read_data = {st.init_volume, st.vol_rising, st.env_period};
            default:       r.read_data = ReadOpen;
          endcase
        end
        default: ;
      endcase
      r.sample = st.sample_hold;
      r.channel_on = st.enabled;
      awaited_q.push_back(r);
    endfunction

    function void check_result(logic [15:0] tdata);
      result_t got;
      result_t want;
      got = tdata[12:0];
      if (awaited_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: sample=%0d read=%02h on=%0b",
                   got.sample, got.read_data, got.channel_on);
        mismatches++;
      end else begin
        want = awaited_q.pop_front();
        if (got.sample !== want.sample || got.read_data !== want.read_data ||
            got.channel_on !== want.channel_on) begin
          if (mismatches < 10)
            $display("mismatch: exp sample=%0d read=%02h on=%0b, got sample=%0d read=%02h on=%0b",
                     want.sample, want.read_data, want.channel_on,
                     got.sample, got.read_data, got.channel_on);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // reg_addr[2:0], write_data[10:3], zero [15:11]
  logic [2:0]  s_tuser;   // action[2:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // sample[3:0], read_data[11:4], channel_on[12], zero [15:13]

  channel_tracker chan_sb;
  int src_idle_pct;
  int snk_idle_pct;
  int items_sent;
  int cycles;

  square_wave_sound_channel_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run if the stream stops moving.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sink: drop ready at random, at the rate the current phase asks.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Check every result item that the sink takes.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) chan_sb.check_result(m_tdata);
  end

  // Offer one event item and hold it until accepted. Enter and leave on a falling edge.
  task automatic send_event(input logic [2:0] act, input logic [2:0] addr,
                            input logic [7:0] din);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {5'd0, din, addr};
    do @(posedge clk_i); while (!s_tready);
    chan_sb.note_event(act, addr, din);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Program and trigger a note, then let it play under a mix of ticks, reads and writes.
  task automatic play_note();
    logic [7:0] env_byte;
    logic [7:0] lo_byte;
    logic [7:0] hi_byte;
    int         n;
    int         pick;
    env_byte = 8'($urandom_range(255));
    if ($urandom_range(9) != 0) env_byte[7:4] = 4'($urandom_range(15, 4));
    // Keep the frequency high most of the time so the duty position moves quickly.
    lo_byte = ($urandom_range(99) < 80) ? 8'($urandom_range(255, 8'hC0))
                                        : 8'($urandom_range(255));
    hi_byte = 8'($urandom_range(255));
    hi_byte[7] = 1'b1;
    if ($urandom_range(99) < 80) hi_byte[2:0] = 3'd7;
    send_event(ACT_WRITE, ADDR_SWEEP, 8'($urandom_range(255)));
    send_event(ACT_WRITE, ADDR_DUTY_LEN, 8'($urandom_range(255)));
    send_event(ACT_WRITE, ADDR_ENVELOPE, env_byte);
    send_event(ACT_WRITE, ADDR_FREQ_LO, lo_byte);
    send_event(ACT_WRITE, ADDR_FREQ_HI, hi_byte);
    n = $urandom_range(60, 15);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 60)      send_event(ACT_CLOCK, 3'($urandom_range(7)), 8'($urandom_range(255)));
      else if (pick < 68) send_event(ACT_LENGTH, 3'($urandom_range(7)), 8'($urandom_range(255)));
      else if (pick < 78) send_event(ACT_SWEEP, 3'($urandom_range(7)), 8'($urandom_range(255)));
      else if (pick < 88) send_event(ACT_ENVELOPE, 3'($urandom_range(7)), 8'($urandom_range(255)));
      else if (pick < 95) send_event(ACT_READ, 3'($urandom_range(7)), 8'($urandom_range(255)));
      else                send_event(ACT_WRITE, 3'($urandom_range(4)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [2:0] act;
    int         rand_start;
    int         done;
    chan_sb = new();
    items_sent = 0;
    src_idle_pct = 8;
    snk_idle_pct = 50;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = ACT_CLOCK;
    rst_ni   = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset readback, stopped timer, spare actions and addresses, register extremes.
    send_event(ACT_READ, ADDR_SWEEP, 8'h00);
    send_event(ACT_READ, 3'd5, 8'h00);
    send_event(ACT_READ, 3'd7, 8'hFF);
    send_event(ACT_CLOCK, ADDR_SWEEP, 8'h00);
    send_event(ActSpareLo, ADDR_FREQ_HI, 8'hFF);
    send_event(ActSpareHi, 3'd7, 8'h00);
    send_event(ACT_WRITE, ADDR_SWEEP, 8'hFF);
    send_event(ACT_READ, ADDR_SWEEP, 8'h00);
    send_event(ACT_WRITE, ADDR_DUTY_LEN, 8'hC0);
    send_event(ACT_READ, ADDR_DUTY_LEN, 8'h00);
    // Envelope write with the top five bits clear switches the channel off.
    send_event(ACT_WRITE, ADDR_ENVELOPE, 8'h00);
    send_event(ACT_WRITE, ADDR_ENVELOPE, 8'hF7);
    send_event(ACT_READ, ADDR_ENVELOPE, 8'h00);
    send_event(ACT_WRITE, ADDR_FREQ_LO, 8'hFF);
    send_event(ACT_WRITE, ADDR_FREQ_HI, 8'hC7);
    send_event(ACT_WRITE, AddrSpare, 8'hFF);
    repeat (3) send_event(ACT_CLOCK, ADDR_SWEEP, 8'h00);
    send_event(ACT_LENGTH, ADDR_SWEEP, 8'h00);
    send_event(ACT_SWEEP, ADDR_SWEEP, 8'h00);
    send_event(ACT_ENVELOPE, ADDR_SWEEP, 8'h00);
    send_event(ACT_READ, ADDR_FREQ_LO, 8'h00);
    send_event(ACT_READ, ADDR_FREQ_HI, 8'h00);

    // Random: mostly well-formed notes, some raw noise; idling shifts between thirds.
    rand_start = items_sent;
    while (items_sent - rand_start < RandomItems) begin
      done = items_sent - rand_start;
      if (done >= 2 * RandomItems / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (done >= RandomItems / 3) begin
        src_idle_pct = 50;
        snk_idle_pct = 8;
      end
      if ($urandom_range(99) < 85) begin
        play_note();
      end else begin
        act = ($urandom_range(99) < 4) ? (($urandom_range(1) != 0) ? ActSpareHi : ActSpareLo)
                                       : 3'($urandom_range(5));
        send_event(act, 3'($urandom_range(7)), 8'($urandom_range(255)));
      end
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every awaited result, then a few more cycles for strays.
    while (chan_sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (chan_sb.mismatches == 0 && chan_sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/sqch_pkg.sv
rtl/core/sqch_step.sv
rtl/core/square_wave_sound_channel_core.sv
tb/tb_square_wave_sound_channel_core.sv
